// ===== sv/hangul_jamo_syllable_composer_unit_macros.svh =====
// Assertion macros used by the composer's checker file.
`ifndef HANGUL_JAMO_SYLLABLE_COMPOSER_UNIT_MACROS_SVH
`define HANGUL_JAMO_SYLLABLE_COMPOSER_UNIT_MACROS_SVH

// Same-cycle implication under the active-low reset.
`define HJSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hjsc assertion failed");

// Next-cycle implication under the active-low reset.
`define HJSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hjsc assertion failed");

`endif

// ===== sv/hjsc_pkg.sv =====
// Types, codes and jamo tables of the Hangul syllable composer.
package hjsc_pkg;

  typedef enum logic [1:0] {
    MODE_CHAR   = 2'd0,
    MODE_BKSP   = 2'd1,
    MODE_COMMIT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  localparam logic [4:0]  IDX_NONE    = 5'h1F;
  localparam logic [15:0] SYL_BASE    = 16'hAC00;
  localparam logic [15:0] VOWEL_FIRST = 16'h314F;
  localparam logic [15:0] VOWEL_LAST  = 16'h3163;
  localparam int unsigned NUM_INIT    = 19;
  localparam int unsigned NUM_VOWEL   = 21;
  localparam int unsigned NUM_FINAL   = 28;

  typedef struct packed {
    logic       iv;
    logic [4:0] ii;
    logic       vv;
    logic [4:0] vi;
    logic [4:0] fi;
  } syl_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] text;
    logic        repl;
    logic        acc;
    logic        last;
  } res_t;

  function automatic logic [15:0] cons_code(logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:    r = 16'h3131;
      5'd1:    r = 16'h3132;
      5'd2:    r = 16'h3134;
      5'd3:    r = 16'h3137;
      5'd4:    r = 16'h3138;
      5'd5:    r = 16'h3139;
      5'd6:    r = 16'h3141;
      5'd7:    r = 16'h3142;
      5'd8:    r = 16'h3143;
      5'd9:    r = 16'h3145;
      5'd10:   r = 16'h3146;
      5'd11:   r = 16'h3147;
      5'd12:   r = 16'h3148;
      5'd13:   r = 16'h3149;
      5'd14:   r = 16'h314A;
      5'd15:   r = 16'h314B;
      5'd16:   r = 16'h314C;
      5'd17:   r = 16'h314D;
      5'd18:   r = 16'h314E;
      default: r = 16'h3131;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] cons_lookup(logic [15:0] c);
    logic [4:0] r;
    case (c)
      16'h3131: r = 5'd0;
      16'h3132: r = 5'd1;
      16'h3134: r = 5'd2;
      16'h3137: r = 5'd3;
      16'h3138: r = 5'd4;
      16'h3139: r = 5'd5;
      16'h3141: r = 5'd6;
      16'h3142: r = 5'd7;
      16'h3143: r = 5'd8;
      16'h3145: r = 5'd9;
      16'h3146: r = 5'd10;
      16'h3147: r = 5'd11;
      16'h3148: r = 5'd12;
      16'h3149: r = 5'd13;
      16'h314A: r = 5'd14;
      16'h314B: r = 5'd15;
      16'h314C: r = 5'd16;
      16'h314D: r = 5'd17;
      16'h314E: r = 5'd18;
      default:  r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] init_to_final(logic [4:0] c);
    logic [4:0] r;
    case (c)
      5'd0:    r = 5'd1;
      5'd1:    r = 5'd2;
      5'd2:    r = 5'd4;
      5'd3:    r = 5'd7;
      5'd5:    r = 5'd8;
      5'd6:    r = 5'd16;
      5'd7:    r = 5'd17;
      5'd9:    r = 5'd19;
      5'd10:   r = 5'd20;
      5'd11:   r = 5'd21;
      5'd12:   r = 5'd22;
      5'd14:   r = 5'd23;
      5'd15:   r = 5'd24;
      5'd16:   r = 5'd25;
      5'd17:   r = 5'd26;
      5'd18:   r = 5'd27;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] final_to_init(logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd1:    r = 5'd0;
      5'd2:    r = 5'd1;
      5'd4:    r = 5'd2;
      5'd7:    r = 5'd3;
      5'd8:    r = 5'd5;
      5'd16:   r = 5'd6;
      5'd17:   r = 5'd7;
      5'd19:   r = 5'd9;
      5'd20:   r = 5'd10;
      5'd21:   r = 5'd11;
      5'd22:   r = 5'd12;
      5'd23:   r = 5'd14;
      5'd24:   r = 5'd15;
      5'd25:   r = 5'd16;
      5'd26:   r = 5'd17;
      5'd27:   r = 5'd18;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] split_keep(logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd3:    r = 5'd1;
      5'd5:    r = 5'd4;
      5'd6:    r = 5'd4;
      5'd9:    r = 5'd8;
      5'd10:   r = 5'd8;
      5'd11:   r = 5'd8;
      5'd12:   r = 5'd8;
      5'd13:   r = 5'd8;
      5'd14:   r = 5'd8;
      5'd15:   r = 5'd8;
      5'd18:   r = 5'd17;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] split_pull(logic [4:0] f);
    logic [4:0] r;
    case (f)
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd12;
      5'd6:    r = 5'd18;
      5'd10:   r = 5'd6;
      5'd11:   r = 5'd7;
      5'd12:   r = 5'd9;
      5'd13:   r = 5'd16;
      5'd14:   r = 5'd17;
      5'd15:   r = 5'd18;
      5'd18:   r = 5'd9;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] combine_final(logic [4:0] base, logic [4:0] add);
    logic [4:0] r;
    r = 5'd0;
    case (base)
      5'd1:  if (add == 5'd9) r = 5'd3;
      5'd4: begin
        if (add == 5'd12) r = 5'd5;
        else if (add == 5'd18) r = 5'd6;
      end
      5'd8: begin
        case (add)
          5'd0:    r = 5'd9;
          5'd6:    r = 5'd10;
          5'd7:    r = 5'd11;
          5'd9:    r = 5'd12;
          5'd16:   r = 5'd13;
          5'd17:   r = 5'd14;
          5'd18:   r = 5'd15;
          default: r = 5'd0;
        endcase
      end
      5'd17: if (add == 5'd9) r = 5'd18;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] combine_vowel(logic [4:0] base, logic [4:0] add);
    logic [4:0] r;
    r = IDX_NONE;
    case (base)
      5'd8: begin
        if (add == 5'd0) r = 5'd9;
        else if (add == 5'd1) r = 5'd10;
        else if (add == 5'd20) r = 5'd11;
      end
      5'd13: begin
        if (add == 5'd4) r = 5'd14;
        else if (add == 5'd5) r = 5'd15;
        else if (add == 5'd20) r = 5'd16;
      end
      5'd18: if (add == 5'd20) r = 5'd19;
      default: r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] vowel_base(logic [4:0] v);
    logic [4:0] r;
    case (v) inside
      [5'd9:5'd11]:  r = 5'd8;
      [5'd14:5'd16]: r = 5'd13;
      5'd19:         r = 5'd18;
      default:       r = IDX_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] syl_code(logic [4:0] i, logic [4:0] v, logic [4:0] f);
    logic [9:0]  iv_sum;
    logic [14:0] ivf;
    iv_sum = 10'(i) * 10'd21 + 10'(v);
    ivf    = 15'(iv_sum) * 15'd28 + 15'(f);
    return SYL_BASE + 16'(ivf);
  endfunction

  function automatic logic [15:0] cur_code(syl_t s);
    logic [4:0] i;
    logic [4:0] v;
    logic [4:0] f;
    i = (s.ii < 5'(NUM_INIT)) ? s.ii : 5'd0;
    v = (s.vi >= 5'(NUM_VOWEL)) ? s.vi - 5'(NUM_VOWEL) : s.vi;
    f = (s.fi >= 5'(NUM_FINAL)) ? s.fi - 5'(NUM_FINAL) : s.fi;
    return s.vv ? syl_code(i, v, f) : cons_code(i);
  endfunction

endpackage

// ===== sv/hangul_jamo_syllable_composer_unit.sv =====
// Hangul two-set keystroke composer: keystrokes in, syllable display updates out.
// A keystroke is registered, then decoded against the syllable being built in one
// pass, and its one or two results enter a four-entry result queue. A new keystroke
// can be taken every cycle while the queue holds two or fewer results; results leave
// one per cycle while out_stall_i is low, so a keystroke that pulls a final into a
// new syllable yields two results in turn. A keystroke passes the input register
// and the result queue before its first result appears. Kind 1 carries a code point,
// kind 2 clears the shown syllable, and kind 0 reports a keystroke the composer did
// not consume; last_of_run marks the final result of each keystroke.
module hangul_jamo_syllable_composer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] text_code_o,
  output logic        replaces_previous_o,
  output logic        accepted_o,
  output logic        last_of_run_o
);

  logic           in_valid_q, in_valid_d;
  logic [1:0]     mode_q;
  logic [15:0]    code_q;
  hjsc_pkg::syl_t syl_q, syl_d;
  hjsc_pkg::syl_t step_nxt;
  hjsc_pkg::res_t res0;
  hjsc_pkg::res_t res1;
  hjsc_pkg::res_t head;
  logic           two;
  logic           room;
  logic           advance;
  logic           take;

  assign advance    = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    syl_d      = advance ? step_nxt : syl_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      syl_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      syl_q      <= syl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mode_q <= mode_i;
      code_q <= char_code_i;
    end
  end

  hjsc_step u_step (
    .cur_i  (syl_q),
    .mode_i (mode_q),
    .code_i (code_q),
    .nxt_o  (step_nxt),
    .res0_o (res0),
    .res1_o (res1),
    .two_o  (two)
  );

  hjsc_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (advance),
    .push1_i (advance && two),
    .data0_i (res0),
    .data1_i (res1),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .data_o  (head)
  );

  assign kind_o              = head.kind;
  assign text_code_o         = head.text;
  assign replaces_previous_o = head.repl;
  assign accepted_o          = head.acc;
  assign last_of_run_o       = head.last;

endmodule

// ===== sv/hjsc_step.sv =====
// Keystroke decode and syllable update: next syllable state and up to two results.
module hjsc_step (
  input  hjsc_pkg::syl_t       cur_i,
  input  logic [1:0]           mode_i,
  input  logic [15:0]          code_i,
  output hjsc_pkg::syl_t       nxt_o,
  output hjsc_pkg::res_t       res0_o,
  output hjsc_pkg::res_t       res1_o,
  output logic                 two_o
);

  hjsc_pkg::syl_t nxt;
  hjsc_pkg::syl_t cleared;
  hjsc_pkg::res_t r0;
  hjsc_pkg::res_t r1;
  logic           two;
  logic [4:0]     cons_idx;
  logic [4:0]     vow_idx;
  logic           is_vowel;
  logic [4:0]     tgt_f;
  logic [4:0]     merged_v;
  logic [4:0]     keep_f;
  logic [4:0]     pull_i;
  logic [4:0]     base_v;

  assign cons_idx = hjsc_pkg::cons_lookup(code_i);
  assign is_vowel = code_i inside {[hjsc_pkg::VOWEL_FIRST:hjsc_pkg::VOWEL_LAST]};
  assign vow_idx  = 5'(code_i - hjsc_pkg::VOWEL_FIRST);
  assign tgt_f    = (cur_i.fi == 5'd0) ? hjsc_pkg::init_to_final(cons_idx)
                                       : hjsc_pkg::combine_final(cur_i.fi, cons_idx);
  assign merged_v = hjsc_pkg::combine_vowel(cur_i.vi, vow_idx);
  assign keep_f   = hjsc_pkg::split_keep(cur_i.fi);
  assign pull_i   = (keep_f != 5'd0) ? hjsc_pkg::split_pull(cur_i.fi)
                                     : hjsc_pkg::final_to_init(cur_i.fi);
  assign base_v   = hjsc_pkg::vowel_base(cur_i.vi);
  assign cleared  = '0;

  always_comb begin
    nxt = cur_i;
    r0  = '0;
    r1  = '0;
    two = 1'b0;
    case (hjsc_pkg::mode_e'(mode_i))
      hjsc_pkg::MODE_BKSP: begin
        if (cur_i.fi != 5'd0) begin
          nxt.fi  = keep_f;
          r0.kind = hjsc_pkg::KIND_TEXT;
          r0.text = hjsc_pkg::cur_code(nxt);
          r0.repl = 1'b1;
          r0.acc  = 1'b1;
        end else if (cur_i.vv) begin
          if (base_v == hjsc_pkg::IDX_NONE) begin
            nxt.vv = 1'b0;
            nxt.vi = 5'd0;
          end else begin
            nxt.vi = base_v;
          end
          r0.kind = hjsc_pkg::KIND_TEXT;
          r0.text = hjsc_pkg::cur_code(nxt);
          r0.repl = 1'b1;
          r0.acc  = 1'b1;
        end else if (cur_i.iv) begin
          nxt     = cleared;
          r0.kind = hjsc_pkg::KIND_CLEAR;
          r0.acc  = 1'b1;
        end
      end
      hjsc_pkg::MODE_CHAR: begin
        if (cons_idx != hjsc_pkg::IDX_NONE) begin
          r0.kind = hjsc_pkg::KIND_TEXT;
          r0.acc  = 1'b1;
          if (cur_i.iv && cur_i.vv && tgt_f != 5'd0) begin
            nxt.fi  = tgt_f;
            r0.repl = 1'b1;
          end else begin
            nxt = '{iv: 1'b1, ii: cons_idx, vv: 1'b0, vi: 5'd0, fi: 5'd0};
          end
          r0.text = hjsc_pkg::cur_code(nxt);
        end else if (is_vowel) begin
          r0.kind = hjsc_pkg::KIND_TEXT;
          r0.acc  = 1'b1;
          r0.text = code_i;
          if (!cur_i.iv) begin
            nxt = cur_i;
          end else if (!cur_i.vv) begin
            nxt.vv  = 1'b1;
            nxt.vi  = vow_idx;
            nxt.fi  = 5'd0;
            r0.text = hjsc_pkg::cur_code(nxt);
            r0.repl = 1'b1;
          end else if (cur_i.fi == 5'd0) begin
            if (merged_v != hjsc_pkg::IDX_NONE) begin
              nxt.vi  = merged_v;
              r0.text = hjsc_pkg::cur_code(nxt);
              r0.repl = 1'b1;
            end else begin
              nxt = cleared;
            end
          end else if (pull_i == hjsc_pkg::IDX_NONE) begin
            nxt = cleared;
          end else begin
            nxt.fi  = keep_f;
            r0.text = hjsc_pkg::cur_code(nxt);
            r0.repl = 1'b1;
            nxt     = '{iv: 1'b1, ii: pull_i, vv: 1'b1, vi: vow_idx, fi: 5'd0};
            r1.kind = hjsc_pkg::KIND_TEXT;
            r1.text = hjsc_pkg::cur_code(nxt);
            r1.acc  = 1'b1;
            two     = 1'b1;
          end
        end else begin
          nxt = cleared;
        end
      end
      default: begin
        nxt = cleared;
      end
    endcase
    r0.last = ~two;
    r1.last = 1'b1;
  end

  assign nxt_o  = nxt;
  assign res0_o = r0;
  assign res1_o = r1;
  assign two_o  = two;

endmodule

// ===== sv/hjsc_res_fifo.sv =====
// Four-entry result queue that takes one or two results per cycle and gives one per pop.
module hjsc_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push0_i,
  input  logic           push1_i,
  input  hjsc_pkg::res_t data0_i,
  input  hjsc_pkg::res_t data1_i,
  input  logic           pop_i,
  output logic           room_o,
  output logic           valid_o,
  output hjsc_pkg::res_t data_o
);

  hjsc_pkg::res_t mem_q [4];
  logic [1:0]     wr_ptr_q, wr_ptr_d;
  logic [1:0]     rd_ptr_q, rd_ptr_d;
  logic [2:0]     count_q, count_d;
  logic [1:0]     wr_ptr_nx;
  logic           do_pop;

  assign do_pop    = pop_i && (count_q != 3'd0);
  assign wr_ptr_nx = wr_ptr_q + 2'd1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + 2'(push0_i) + 2'(push1_i);
    rd_ptr_d = rd_ptr_q + 2'(do_pop);
    count_d  = count_q + 3'(push0_i) + 3'(push1_i) - 3'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_nx] <= data1_i;
    end
  end

  assign room_o  = (count_q <= 3'd2);
  assign valid_o = (count_q != 3'd0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ===== sv/hjsc_checker.sv =====
// Port-level checks of the composer's result stream, bound to the top level.
`include "hangul_jamo_syllable_composer_unit_macros.svh"

module hjsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [15:0] text_code_o,
  input logic        replaces_previous_o,
  input logic        accepted_o,
  input logic        last_of_run_o
);

  `HJSC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(text_code_o) && $stable(kind_o) && $stable(last_of_run_o))
  `HJSC_ASSERT_NOW(a_no_text_clean, clk_i, rst_ni, out_valid_o && kind_o != hjsc_pkg::KIND_TEXT, text_code_o == 16'd0 && !replaces_previous_o)
  `HJSC_ASSERT_NOW(a_reject_single, clk_i, rst_ni, out_valid_o && !accepted_o, kind_o == hjsc_pkg::KIND_NONE && last_of_run_o)
  `HJSC_ASSERT_NOW(a_pair_first, clk_i, rst_ni, out_valid_o && !last_of_run_o, kind_o == hjsc_pkg::KIND_TEXT && replaces_previous_o && accepted_o)

endmodule

bind hangul_jamo_syllable_composer_unit hjsc_checker u_hjsc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .kind_o              (kind_o),
  .text_code_o         (text_code_o),
  .replaces_previous_o (replaces_previous_o),
  .accepted_o          (accepted_o),
  .last_of_run_o       (last_of_run_o)
);
